FILE: rtl/core/utf8d_pkg.sv
// shared types, widths and the cp1252 c1 lookup for the utf-8 decoder
`default_nettype none

package utf8d_pkg;

  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int ST_W   = 3;
  localparam int PEND_W = 2;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_UNMAPPED = 3'd1,
    ST_STRAY    = 3'd2,
    ST_BADLEAD  = 3'd3,
    ST_MISSING  = 3'd4,
    ST_TRUNC    = 3'd5
  } status_t;

  // zero marks a hole in the table
  function automatic logic [15:0] cp1252_lookup(input logic [4:0] idx);
    logic [15:0] val;
    case (idx)
      5'd0:    val = 16'h20AC;
      5'd2:    val = 16'h201A;
      5'd3:    val = 16'h0192;
      5'd4:    val = 16'h201E;
      5'd5:    val = 16'h2026;
      5'd6:    val = 16'h2020;
      5'd7:    val = 16'h2021;
      5'd8:    val = 16'h02C6;
      5'd9:    val = 16'h2030;
      5'd10:   val = 16'h0160;
      5'd11:   val = 16'h2039;
      5'd12:   val = 16'h0152;
      5'd14:   val = 16'h017D;
      5'd17:   val = 16'h2018;
      5'd18:   val = 16'h2019;
      5'd19:   val = 16'h201C;
      5'd20:   val = 16'h201D;
      5'd21:   val = 16'h2022;
      5'd22:   val = 16'h2013;
      5'd23:   val = 16'h2014;
      5'd24:   val = 16'h02DC;
      5'd25:   val = 16'h2122;
      5'd26:   val = 16'h0161;
      5'd27:   val = 16'h203A;
      5'd28:   val = 16'h0153;
      5'd30:   val = 16'h017E;
      5'd31:   val = 16'h0178;
      default: val = 16'h0000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/utf8d_in_if.sv
// input channel: one raw byte per word with an end-of-string flag
`default_nettype none

interface utf8d_in_if;
  logic                          valid;
  logic                          ready;
  logic [utf8d_pkg::BYTE_W-1:0]  byte_in;
  logic                          last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/utf8d_out_if.sv
// result channel: decoded code point, status and end-of-string flag per word
`default_nettype none

interface utf8d_out_if;
  logic                        valid;
  logic                        ready;
  logic [utf8d_pkg::CP_W-1:0]  cp_val;
  logic [utf8d_pkg::ST_W-1:0]  status;
  logic                        final_result;

  modport source (output valid, output cp_val, output status, output final_result,
                  input ready);
  modport sink   (input valid, input cp_val, input status, input final_result,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/utf8_decoder_with_cp1252_fallback_core.sv
// utf-8 decoder with cp1252 fallback for c1 bytes
// a byte waits in the input register, and its result word is held in the result
//   register until out_ch.ready takes it; zero or one result word per byte
// throughput: one byte per cycle, set by the single decode step between the input
//   register and the result register, while no held result word is left waiting
// reset: synchronous active-low rst_n clears both stages and the decode state
`default_nettype none

module utf8_decoder_with_cp1252_fallback_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  utf8d_in_if.sink   in_ch,
  utf8d_out_if.source out_ch
);
  import utf8d_pkg::*;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_adv;

  logic [PEND_W-1:0] pend_r, pend_nxt, pend_dec;
  logic [CP_W-1:0]   part_r, part_nxt, merged;
  logic              disc_r, disc_nxt;

  logic              res_v;
  logic [CP_W-1:0]   res_cp;
  status_t           res_st;
  logic              res_fin;
  logic [15:0]       c1_val;

  logic              out_valid_r;
  logic [CP_W-1:0]   out_cp_r;
  status_t           out_st_r;
  logic              out_fin_r;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.byte_in;
      s1_last_r <= in_ch.last_byte;
    end
  end

  assign pend_dec = pend_r - 2'd1;
  assign c1_val   = cp1252_lookup(s1_byte_r[4:0]);

  always_comb begin
    case (pend_dec)
      2'd2:    merged = part_r | (CP_W'(s1_byte_r[5:0]) << 12);
      2'd1:    merged = part_r | (CP_W'(s1_byte_r[5:0]) << 6);
      default: merged = part_r | CP_W'(s1_byte_r[5:0]);
    endcase
  end

  always_comb begin
    pend_nxt = pend_r;
    part_nxt = part_r;
    disc_nxt = disc_r;
    res_v    = 1'b0;
    res_cp   = '0;
    res_st   = ST_OK;
    res_fin  = s1_last_r;
    if (disc_r) begin
      if (s1_last_r) begin
        disc_nxt = 1'b0;
      end
    end else if (pend_r != '0) begin
      if (s1_byte_r[7:6] != 2'b10) begin
        res_v = 1'b1; res_st = ST_MISSING; res_fin = 1'b1;
        pend_nxt = '0; part_nxt = '0; disc_nxt = !s1_last_r;
      end else if (pend_dec == '0) begin
        res_v = 1'b1; res_cp = merged;
        pend_nxt = '0; part_nxt = '0;
      end else if (s1_last_r) begin
        res_v = 1'b1; res_st = ST_TRUNC; res_fin = 1'b1;
        pend_nxt = '0; part_nxt = '0; disc_nxt = 1'b0;
      end else begin
        pend_nxt = pend_dec;
        part_nxt = merged;
      end
    end else begin
      case (s1_byte_r) inside
        [8'h00:8'h7F]: begin
          res_v  = 1'b1;
          res_cp = CP_W'(s1_byte_r);
        end
        [8'h80:8'h9F]: begin
          res_v = 1'b1;
          if (c1_val == '0) begin
            res_st = ST_UNMAPPED; res_fin = 1'b1; disc_nxt = !s1_last_r;
          end else begin
            res_cp = CP_W'(c1_val);
          end
        end
        [8'hA0:8'hBF]: begin
          res_v = 1'b1; res_st = ST_STRAY; res_fin = 1'b1; disc_nxt = !s1_last_r;
        end
        [8'hC0:8'hF7]: begin
          if (s1_last_r) begin
            res_v = 1'b1; res_st = ST_TRUNC; res_fin = 1'b1;
          end else if (s1_byte_r[7:5] == 3'b110) begin
            pend_nxt = 2'd1;
            part_nxt = CP_W'(s1_byte_r[4:0]) << 6;
          end else if (s1_byte_r[7:4] == 4'b1110) begin
            pend_nxt = 2'd2;
            part_nxt = CP_W'(s1_byte_r[3:0]) << 12;
          end else begin
            pend_nxt = 2'd3;
            part_nxt = CP_W'(s1_byte_r[2:0]) << 18;
          end
        end
        default: begin
          res_v = 1'b1; res_st = ST_BADLEAD; res_fin = 1'b1; disc_nxt = !s1_last_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      part_r      <= '0;
      disc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      pend_r      <= pend_nxt;
      part_r      <= part_nxt;
      disc_r      <= disc_nxt;
      out_valid_r <= res_v;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_v) begin
      out_cp_r  <= res_cp;
      out_st_r  <= res_st;
      out_fin_r <= res_fin;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cp_val       = out_cp_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.final_result = out_fin_r;

  // skipping a failed string never overlaps an open sequence
  a_disc_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> pend_r == '0)
    else $error("discard with sequence open");

  // partial bits only live while continuations are due
  a_part_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == '0 |-> part_r == '0)
    else $error("stale partial value");

  // an error word carries no code point and ends its string
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != ST_OK |-> out_cp_r == '0 && out_fin_r)
    else $error("malformed error word");

  // a result word only follows a byte that left the input stage
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result word without source byte");

endmodule

`default_nettype wire
